/* design/max_heap_priority_queue_defines.svh */
// Assertion macros for the priority queue top level.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define MHPQ_ASSERT(lbl, clk_s, rst_ns, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MHPQ_NEVER(lbl, clk_s, rst_ns, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) !(cond)) else $error(msg);

`else

`define MHPQ_ASSERT(lbl, clk_s, rst_ns, prop, msg)
`define MHPQ_NEVER(lbl, clk_s, rst_ns, cond, msg)

`endif

`endif

/* design/mhpq_pkg.sv */
// Types and codes shared by the priority queue modules.
package mhpq_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_FIELD_W = 7;

	// Request modes.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic                      mode;
		logic signed [VALUE_W-1:0] value;
	} mhpq_req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] top_value;
		logic [COUNT_FIELD_W-1:0]  entry_count;
	} mhpq_rsp_t;

	// Command broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] value;
	} mhpq_cmd_t;

endpackage

/* design/mhpq_cell.sv */
// One cell of the sorted chain: holds one entry and trades with its neighbors.
module mhpq_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                               clk,
	input  mhpq_pkg::mhpq_cmd_t                cmd,
	input  logic [CNT_W-1:0]                   count,
	input  logic signed [mhpq_pkg::VALUE_W-1:0] left_entry,
	input  logic                               left_keep,
	input  logic signed [mhpq_pkg::VALUE_W-1:0] right_entry,
	output logic signed [mhpq_pkg::VALUE_W-1:0] entry,
	output logic                               keep
);
	import mhpq_pkg::*;

	logic signed [VALUE_W-1:0] entry_q;
	logic                      occupied;

	// The cell holds a live entry when it lies below the fill level.
	assign occupied = count > CNT_W'(INDEX);

	// An entry at least as large as the new value stays where it is.
	assign keep  = occupied && (entry_q >= cmd.value);
	assign entry = entry_q;

	// Insert opens a gap at the first smaller entry; remove shifts toward the head.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (keep) begin
				entry_q <= entry_q;
			end else if (left_keep) begin
				entry_q <= cmd.value;
			end else begin
				entry_q <= left_entry;
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* design/mhpq_out_buf.sv */
// Two-entry result buffer between the queue core and the result channel.
module mhpq_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mhpq_pkg::mhpq_rsp_t push_data,
	output logic                full,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mhpq_pkg::mhpq_rsp_t rsp
);
	import mhpq_pkg::*;

	mhpq_rsp_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign rsp_valid = fill_q != 2'd0;
	assign full      = fill_q == 2'd2;
	assign rsp       = slot_q[rd_ptr_q];
	assign pop       = rsp_valid && !rsp_stall;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/max_heap_priority_queue.sv */
// Priority queue top level: a chain of sorted cells and a two-entry result buffer.
// A request's result is registered in the two-entry result buffer when it is taken.
// Throughput: one request per cycle while the buffer is not full, so requests keep
// flowing while one result waits; every cell compares and shifts in the same cycle.
// Reset clears the entry count and the result buffer at once; cell contents
// are undefined until written and need no clearing pass.
module max_heap_priority_queue #(
	parameter int CAPACITY = 127
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mhpq_pkg::mhpq_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mhpq_pkg::mhpq_rsp_t rsp
);
	import mhpq_pkg::*;

	`include "max_heap_priority_queue_defines.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_next;
	logic [CNT_W+COUNT_FIELD_W-1:0] count_ext;
	logic                      is_full;
	logic                      is_empty;
	logic                      req_fire;
	logic                      buf_full;
	mhpq_cmd_t                 cmd;
	mhpq_rsp_t                 result;
	logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
	logic                      cell_keep  [CAPACITY];

	assign req_stall = buf_full;
	assign req_fire  = req_valid && !req_stall;
	assign is_full   = count_q == CNT_W'(CAPACITY);
	assign is_empty  = count_q == '0;

	// Command to the chain; flagged requests leave it unchanged.
	always_comb begin
		cmd.ins   = req_fire && (req.mode == MODE_INSERT) && !is_full;
		cmd.rem   = req_fire && (req.mode == MODE_REMOVE) && !is_empty;
		cmd.value = req.value;
	end

	// Entry count after the request.
	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Result: the head of the chain is the maximum, so it is known before the update.
	assign count_ext = {{COUNT_FIELD_W{1'b0}}, count_next};

	always_comb begin
		result.status      = STATUS_DONE;
		result.top_value   = '0;
		result.entry_count = count_ext[COUNT_FIELD_W-1:0];
		if (req.mode == MODE_INSERT) begin
			if (is_full) begin
				result.status    = STATUS_FULL;
				result.top_value = cell_entry[0];
			end else if (is_empty || (req.value > cell_entry[0])) begin
				result.top_value = req.value;
			end else begin
				result.top_value = cell_entry[0];
			end
		end else begin
			if (is_empty) begin
				result.status = STATUS_EMPTY;
			end else if (count_q >= CNT_W'(2)) begin
				result.top_value = cell_entry[1];
			end
		end
	end

	// Sorted chain, largest entry at the head.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_entry;
		logic                      left_keep;
		logic signed [VALUE_W-1:0] right_entry;

		if (i == 0) begin : g_head
			assign left_entry = '0;
			assign left_keep  = 1'b1;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_keep  = cell_keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		mhpq_cell #(
			.INDEX(i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_entry (left_entry),
			.left_keep  (left_keep),
			.right_entry(right_entry),
			.entry      (cell_entry[i]),
			.keep       (cell_keep[i])
		);
	end

	mhpq_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (req_fire),
		.push_data(result),
		.full     (buf_full),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Checks on the chain and the count.
	`MHPQ_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(CAPACITY), "entry count above capacity")
	`MHPQ_ASSERT(a_head_sorted, clk, arst_n, (count_q >= CNT_W'(2)) |-> (cell_entry[0] >= cell_entry[1]), "head of chain out of order")
	`MHPQ_ASSERT(a_insert_grows, clk, arst_n, cmd.ins |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not grow the count")

endmodule

/* dv/heap_result_check.sv */
// Request and result monitor for the priority queue: models the heap and checks every result.
module heap_result_check #(
	parameter int CAPACITY = 127
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  mhpq_pkg::mhpq_req_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  mhpq_pkg::mhpq_rsp_t rsp,
	output int                  fail_count,
	output int                  pending
);
	import mhpq_pkg::*;

	// Model of the heap contents and the number of entries held.
	logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
	int held;
	mhpq_rsp_t expected_rsp_q[$];

	initial begin
		held = 0;
		fail_count = 0;
		pending = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic signed [VALUE_W-1:0] got,
			input logic signed [VALUE_W-1:0] want);
		$display("ERROR at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Applies one request to the model heap and returns the result it should produce.
	function automatic mhpq_rsp_t apply_request(input mhpq_req_t r);
		mhpq_rsp_t res;
		int pos;
		int parent;
		int left;
		int right;
		int pick;
		logic signed [VALUE_W-1:0] tmp;
		res.status = STATUS_DONE;
		if (r.mode == MODE_INSERT) begin
			if (held >= CAPACITY) begin
				res.status = STATUS_FULL;
			end else begin
				// Place the new value last and move it up past smaller parents.
				heap_mem[held] = r.value;
				pos = held;
				held++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (heap_mem[parent] >= heap_mem[pos])
						break;
					tmp = heap_mem[parent];
					heap_mem[parent] = heap_mem[pos];
					heap_mem[pos] = tmp;
					pos = parent;
				end
			end
		end else if (held == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			// Move the last entry to the root and push it down toward the larger child.
			held--;
			heap_mem[0] = heap_mem[held];
			pos = 0;
			forever begin
				left = 2 * pos + 1;
				right = left + 1;
				pick = pos;
				if (left < held && heap_mem[pick] < heap_mem[left])
					pick = left;
				if (right < held && heap_mem[pick] < heap_mem[right])
					pick = right;
				if (pick == pos)
					break;
				tmp = heap_mem[pick];
				heap_mem[pick] = heap_mem[pos];
				heap_mem[pos] = tmp;
				pos = pick;
			end
		end
		res.top_value = (held > 0) ? heap_mem[0] : '0;
		res.entry_count = held[COUNT_FIELD_W-1:0];
		return res;
	endfunction

	// Results are checked before new requests are queued, since a result never
	// belongs to a request taken at the same edge.
	always @(posedge clk) begin
		mhpq_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("result with no request waiting", rsp.top_value, '0);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", VALUE_W'(rsp.status),
							VALUE_W'(want.status));
					if (rsp.top_value !== want.top_value)
						report_mismatch("top_value", rsp.top_value, want.top_value);
					if (rsp.entry_count !== want.entry_count)
						report_mismatch("entry_count", VALUE_W'(rsp.entry_count),
							VALUE_W'(want.entry_count));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(apply_request(req));
			pending = expected_rsp_q.size();
		end
	end

endmodule

/* dv/tb.sv */
// Testbench top for the priority queue: clock, reset, request and stall stimulus, verdict.
module tb;
	import mhpq_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	mhpq_req_t req;
	logic rsp_valid;
	logic rsp_stall;
	mhpq_rsp_t rsp;
	int fail_count;
	int pending;

	// Turns off all random idling, during the long hold-off and near the end of the run.
	bit calm;
	// Asks the receiver for one long hold-off.
	bit hold_rsp;

	max_heap_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	heap_result_check mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard limit on run length.
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off on request, none when calm.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_stall = 1'b1;
				repeat (60) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_stall = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp_stall = 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				rsp_stall = 1'b0;
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	// Mix of extremes, near-zero values that collide often, and full-range values.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom();
		endcase
	endfunction

	// Offers one request, with an optional idle burst first; returns at the
	// falling edge after it was taken.
	task automatic send_request(input logic op, input logic signed [VALUE_W-1:0] operand);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		req.mode = op;
		req.value = operand;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Stops sending until every queued request has its result.
	task automatic wait_for_results();
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Main request sequence and verdict.
	initial begin
		int ins_pct;
		calm = 1'b0;
		hold_rsp = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: remove from an empty heap, extremes, duplicates, ignored value on remove.
		send_request(MODE_REMOVE, 32'sh00000000);
		send_request(MODE_INSERT, 32'sh7FFFFFFF);
		send_request(MODE_INSERT, 32'sh80000000);
		send_request(MODE_INSERT, 32'sh00000000);
		send_request(MODE_INSERT, -32'sd1);
		send_request(MODE_REMOVE, 32'shFFFFFFFF);
		send_request(MODE_REMOVE, 32'sh7FFFFFFF);
		send_request(MODE_INSERT, 32'sd5);
		send_request(MODE_INSERT, 32'sd5);
		send_request(MODE_INSERT, 32'sd5);
		send_request(MODE_INSERT, 32'sd3);
		send_request(MODE_INSERT, 32'sd9);
		send_request(MODE_REMOVE, 32'sh80000000);
		send_request(MODE_REMOVE, 32'sh55555555);
		send_request(MODE_REMOVE, 32'shAAAAAAAA);
		send_request(MODE_INSERT, 32'sd1);
		send_request(MODE_INSERT, -32'sd2);
		send_request(MODE_REMOVE, 32'sh00000000);
		wait_for_results();

		// Fill past capacity so full is reported, then drain past empty.
		repeat (130) send_request(MODE_INSERT, pick_value());
		repeat (132) send_request(MODE_REMOVE, $urandom());

		// Long result hold-off while requests keep coming, then a full pause.
		hold_rsp = 1'b1;
		calm = 1'b1;
		repeat (24) send_request(MODE_INSERT, pick_value());
		calm = 1'b0;
		wait_for_results();

		// Random segments that alternate between growing and shrinking the heap.
		for (int seg = 0; seg < 8; seg++) begin
			if (seg >= 6)
				calm = 1'b1;
			ins_pct = (seg % 2 == 0) ? $urandom_range(70, 95) : $urandom_range(10, 45);
			for (int n = 0; n < 40; n++) begin
				if ($urandom_range(0, 99) < ins_pct)
					send_request(MODE_INSERT, pick_value());
				else
					send_request(MODE_REMOVE, $urandom());
			end
			if (seg == 3)
				wait_for_results();
		end

		wait_for_results();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* max_heap_priority_queue.f */
+incdir+design
design/mhpq_pkg.sv
design/mhpq_cell.sv
design/mhpq_out_buf.sv
design/max_heap_priority_queue.sv
dv/heap_result_check.sv
dv/tb.sv
